/* rtl/core/glpf_pkg.sv */
// Package for the grid local peak finder.
// Holds default sizes, field widths, register indexes and the request word
// passed from the sequencer to the result stage. No dependencies.
package glpf_pkg;

  localparam int MAX_ROWS_DEF    = 32;
  localparam int MAX_COLUMNS_DEF = 32;
  localparam int HEIGHT_BITS_DEF = 16;

  localparam int COORD_BITS     = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 6;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd1;

  typedef struct packed {
    logic                  push;
    logic                  close;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] column;
  } glpf_req_t;

endpackage

/* rtl/core/glpf_if.sv */
// Channel interfaces of the grid local peak finder: height input, peak
// output and configuration write. Each carries valid, ready and its word.
// Depends on glpf_pkg.
interface glpf_height_if #(
  parameter int HEIGHT_BITS = glpf_pkg::HEIGHT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface glpf_peak_if;
  import glpf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] peak_row;
  logic [COORD_BITS-1:0] peak_column;
  logic                  run_last;

  modport source (output valid, output peak_row, output peak_column, output run_last,
                  input ready);
  modport sink (input valid, input peak_row, input peak_column, input run_last,
                output ready);
endinterface

interface glpf_cfg_if;
  import glpf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/glpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glpf_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/glpf_cfg.sv */
// Size registers of the grid local peak finder and their effective values
// (zero reads as one, above the maximum reads as the maximum).
// Depends on glpf_pkg and glpf_cfg_if.
module glpf_cfg #(
  parameter int  MAX_ROWS    = glpf_pkg::MAX_ROWS_DEF,
  parameter int  MAX_COLUMNS = glpf_pkg::MAX_COLUMNS_DEF,
  localparam int EW = $clog2(((MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS) + 1)
) (
  input  logic           clk,
  input  logic           rst,
  glpf_cfg_if.sink       cfg,
  output logic [EW-1:0]  nrows,
  output logic [EW-1:0]  ncols
);
  import glpf_pkg::*;

  logic [CFG_DATA_BITS-1:0] row_count;
  logic [CFG_DATA_BITS-1:0] column_count;

  function automatic logic [EW-1:0] effective(input logic [CFG_DATA_BITS-1:0] count,
                                              input int limit);
    if (count == '0) begin
      effective = EW'(1);
    end else if (int'(count) > limit) begin
      effective = EW'(limit);
    end else begin
      effective = EW'(count);
    end
  endfunction

  assign cfg.ready = 1'b1;
  assign nrows     = effective(row_count, MAX_ROWS);
  assign ncols     = effective(column_count, MAX_COLUMNS);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CFG_DATA_BITS'(1);
      column_count <= CFG_DATA_BITS'(1);
    end else if (cfg.valid) begin
      if (cfg.index == REG_ROW_COUNT) begin
        row_count <= cfg.data;
      end else if (cfg.index == REG_COLUMN_COUNT) begin
        column_count <= cfg.data;
      end
    end
  end

endmodule

/* rtl/core/glpf_seq.sv */
// Sequencer of the grid local peak finder: walks the raster, reads the
// neighbourhood of the cell being decided from the line store, decides,
// writes the new height back and runs the end-of-frame sweep.
// Depends on glpf_pkg and glpf_height_if.
module glpf_seq #(
  parameter int  MAX_ROWS    = glpf_pkg::MAX_ROWS_DEF,
  parameter int  MAX_COLUMNS = glpf_pkg::MAX_COLUMNS_DEF,
  parameter int  HEIGHT_BITS = glpf_pkg::HEIGHT_BITS_DEF,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int EW = $clog2(((MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS) + 1),
  localparam int AW = $clog2(2 * MAX_COLUMNS)
) (
  input  logic                   clk,
  input  logic                   rst,
  glpf_height_if.sink            pixel,
  input  logic [EW-1:0]          nrows,
  input  logic [EW-1:0]          ncols,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [HEIGHT_BITS-1:0] rd_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [HEIGHT_BITS-1:0] wr_data,
  output glpf_pkg::glpf_req_t    req,
  input  logic                   req_ready
);
  import glpf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LAST, S_DECIDE, S_WRITE, S_END
  } state_t;

  typedef enum logic [1:0] {
    SLOT_CENTRE, SLOT_LEFT, SLOT_RIGHT, SLOT_UP
  } slot_t;

  state_t                  state;
  slot_t                   slot;
  slot_t                   rd_slot;
  logic                    rd_pend;
  logic [RW-1:0]           row_pos;
  logic [CW-1:0]           col_pos;
  logic [RW-1:0]           dr;
  logic [CW-1:0]           dc;
  logic                    bank;
  logic                    has_down;
  logic                    burst;
  logic                    need_l;
  logic                    need_r;
  logic                    need_u;
  logic signed [HEIGHT_BITS-1:0] h_reg;
  logic signed [HEIGHT_BITS-1:0] v_c;
  logic signed [HEIGHT_BITS-1:0] v_l;
  logic signed [HEIGHT_BITS-1:0] v_r;
  logic signed [HEIGHT_BITS-1:0] v_u;

  logic peak;
  logic col_end;
  logic row_end;
  logic dc_end;
  logic next_right;

  function automatic logic [AW-1:0] ram_addr(input logic b, input logic [CW-1:0] col);
    ram_addr = b ? (AW'(col) + AW'(MAX_COLUMNS)) : AW'(col);
  endfunction

  assign col_end    = (EW'(col_pos) + EW'(1)) >= ncols;
  assign row_end    = (EW'(row_pos) + EW'(1)) >= nrows;
  assign dc_end     = (EW'(dc) + EW'(1)) >= ncols;
  assign next_right = (EW'(dc) + EW'(2)) < ncols;

  assign peak = !(need_l && (v_c < v_l)) && !(need_r && (v_c < v_r)) &&
                !(need_u && (v_c < v_u)) && !(has_down && (v_c < h_reg));

  always_comb begin
    unique case (slot)
      SLOT_CENTRE: rd_addr = ram_addr(bank, dc);
      SLOT_LEFT:   rd_addr = ram_addr(bank, need_l ? (dc - CW'(1)) : dc);
      SLOT_RIGHT:  rd_addr = ram_addr(bank, need_r ? (dc + CW'(1)) : dc);
      SLOT_UP:     rd_addr = ram_addr(!bank, dc);
    endcase
  end

  assign rd_en       = (state == S_READ);
  assign wr_en       = (state == S_WRITE);
  assign wr_addr     = ram_addr(row_pos[0], col_pos);
  assign wr_data     = h_reg;
  assign pixel.ready = (state == S_IDLE);

  assign req.push   = (state == S_DECIDE) && peak;
  assign req.close  = (state == S_END);
  assign req.row    = COORD_BITS'(dr);
  assign req.column = COORD_BITS'(dc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      slot    <= SLOT_CENTRE;
      row_pos <= '0;
      col_pos <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      rd_slot <= slot;
      if (rd_pend) begin
        unique case (rd_slot)
          SLOT_CENTRE: v_c <= $signed(rd_data);
          SLOT_LEFT:   v_l <= $signed(rd_data);
          SLOT_RIGHT:  v_r <= $signed(rd_data);
          SLOT_UP:     v_u <= $signed(rd_data);
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (pixel.valid) begin
            h_reg    <= pixel.height;
            dr       <= row_pos - RW'(1);
            dc       <= col_pos;
            bank     <= ~row_pos[0];
            has_down <= 1'b1;
            burst    <= 1'b0;
            need_l   <= (col_pos != '0);
            need_r   <= !col_end;
            need_u   <= (row_pos > RW'(1));
            slot     <= SLOT_CENTRE;
            state    <= (row_pos != '0) ? S_READ : S_WRITE;
          end
        end
        S_READ: begin
          slot <= slot_t'(slot + 2'd1);
          if (slot == SLOT_UP) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!peak || req_ready) begin
            if (!burst) begin
              state <= S_WRITE;
            end else if (dc_end) begin
              state <= S_END;
            end else begin
              dc     <= dc + CW'(1);
              need_l <= 1'b1;
              need_r <= next_right;
              slot   <= SLOT_CENTRE;
              state  <= S_READ;
            end
          end
        end
        S_WRITE: begin
          if (col_end && row_end) begin
            dr       <= row_pos;
            dc       <= '0;
            bank     <= row_pos[0];
            has_down <= 1'b0;
            burst    <= 1'b1;
            need_l   <= 1'b0;
            need_r   <= EW'(1) < ncols;
            need_u   <= (row_pos != '0);
            slot     <= SLOT_CENTRE;
            row_pos  <= '0;
            col_pos  <= '0;
            state    <= S_READ;
          end else if (col_end) begin
            col_pos <= '0;
            row_pos <= row_pos + RW'(1);
            state   <= S_END;
          end else begin
            col_pos <= col_pos + CW'(1);
            state   <= S_END;
          end
        end
        S_END: begin
          if (req_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/glpf_out.sv */
// Result stage: holds the newest peak back until the next one or the end of
// the item shows whether it is the last, then moves it to the output register.
// Depends on glpf_pkg and glpf_peak_if.
module glpf_out (
  input  logic                clk,
  input  logic                rst,
  glpf_peak_if.source         peak,
  input  glpf_pkg::glpf_req_t req,
  output logic                req_ready
);
  import glpf_pkg::*;

  logic                  hold_v;
  logic [COORD_BITS-1:0] hold_row;
  logic [COORD_BITS-1:0] hold_column;
  logic                  out_v;
  logic [COORD_BITS-1:0] out_row;
  logic [COORD_BITS-1:0] out_column;
  logic                  out_last;
  logic                  out_free;

  assign out_free  = !out_v || peak.ready;
  assign req_ready = !hold_v || out_free;

  assign peak.valid       = out_v;
  assign peak.peak_row    = out_row;
  assign peak.peak_column = out_column;
  assign peak.run_last    = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (out_v && peak.ready) begin
        out_v <= 1'b0;
      end
      if ((req.push || req.close) && req_ready) begin
        if (hold_v) begin
          out_v      <= 1'b1;
          out_row    <= hold_row;
          out_column <= hold_column;
          out_last   <= req.close;
        end
        hold_v <= req.push;
        if (req.push) begin
          hold_row    <= req.row;
          hold_column <= req.column;
        end
      end
    end
  end

endmodule

/* rtl/core/grid_local_peak_finder.sv */
// Grid local peak finder, top level: size registers, sequencer, line store, result stage.
// An item makes four store reads on one port, none in row 0; the frame's last item adds a
// last-row sweep with the same reads per column. Output stalls hold the sequencer back.
// A peak moves to the output register once the next peak or the end of its item is taken.
// Synchronous reset: sizes back to one, position to the frame start; line store not cleared.
// Depends on glpf_pkg, glpf_if, glpf_ram, glpf_cfg, glpf_seq and glpf_out.
module grid_local_peak_finder #(
  parameter int MAX_ROWS    = glpf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = glpf_pkg::MAX_COLUMNS_DEF,
  parameter int HEIGHT_BITS = glpf_pkg::HEIGHT_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  glpf_height_if.sink pixel,
  glpf_peak_if.source peak,
  glpf_cfg_if.sink    cfg
);
  import glpf_pkg::*;

  localparam int EW = $clog2(((MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS) + 1);
  localparam int AW = $clog2(2 * MAX_COLUMNS);

  logic [EW-1:0]          nrows;
  logic [EW-1:0]          ncols;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [HEIGHT_BITS-1:0] rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [HEIGHT_BITS-1:0] wr_data;
  glpf_req_t              req;
  logic                   req_ready;

  glpf_cfg #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .nrows (nrows),
    .ncols (ncols)
  );

  glpf_seq #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .nrows     (nrows),
    .ncols     (ncols),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .req       (req),
    .req_ready (req_ready)
  );

  glpf_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (2 * MAX_COLUMNS)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  glpf_out u_out (
    .clk       (clk),
    .rst       (rst),
    .peak      (peak),
    .req       (req),
    .req_ready (req_ready)
  );

endmodule

/* rtl/core/glpf_check.sv */
// Port-level checker for the grid local peak finder and its bind to the top level.
// Depends on grid_local_peak_finder.
module glpf_check (
  input logic clk,
  input logic rst,
  input logic pixel_valid,
  input logic pixel_ready,
  input logic peak_valid,
  input logic peak_ready,
  input logic cfg_ready
);

  a_peak_held: assert property (@(posedge clk)
    !rst && peak_valid && !peak_ready |=> peak_valid)
    else $error("peak word dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk)
    !rst && pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("input taken while an item is still at work");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !peak_valid)
    else $error("peak word valid after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind grid_local_peak_finder glpf_check u_glpf_check (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel.valid),
  .pixel_ready (pixel.ready),
  .peak_valid  (peak.valid),
  .peak_ready  (peak.ready),
  .cfg_ready   (cfg.ready)
);
